// ----- design/trot_gait_foot_trajectory_unit_assert.svh -----
// Assertion macros for the trot gait foot trajectory unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TROT_GAIT_FOOT_TRAJECTORY_UNIT_ASSERT_SVH
`define TROT_GAIT_FOOT_TRAJECTORY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define TGFT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tgft assertion failed: same-cycle check");
// antecedent implies consequent in the following cycle
`define TGFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tgft assertion failed: next-cycle check");
`else
`define TGFT_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TGFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/tgft_pkg.sv -----
// Shared types, constants and table-building functions for the trot gait unit.
// No dependencies; imported by every module of the block.
package tgft_pkg;

  // default geometry
  localparam int TGFT_TABLE_ADDR_BITS = 8;
  localparam int TGFT_PHASE_BITS      = 16;

  // table entries are unsigned Q16 in 0..65536
  localparam int TAB_W = 17;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_INC  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIFT       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BODY_SHIFT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEADZONE   = 3'd4;

  // register reset values
  localparam logic [15:0]        RST_PHASE_INC  = 16'd3277;
  localparam logic [11:0]        RST_LIFT       = 12'd800;
  localparam logic signed [13:0] RST_BODY_SHIFT = 14'sd0;
  localparam logic [11:0]        RST_GAIN       = 12'd64;
  localparam logic [6:0]         RST_DEADZONE   = 7'd5;

  // 2*pi and 1.0 in Q30
  localparam longint unsigned TWO_PI_Q30      = 64'd6746518852;
  localparam longint unsigned HALF_TWO_PI_Q30 = TWO_PI_Q30 / 2;
  localparam longint          ONE_Q30         = 64'sd1073741824;

  typedef struct packed {
    logic signed [7:0] joystick_forward;
    logic              march_in_place;
  } tgft_in_t;

  typedef struct packed {
    logic signed [15:0] foot_x_front_left;
    logic signed [15:0] foot_x_front_right;
    logic signed [15:0] foot_x_rear_left;
    logic signed [15:0] foot_x_rear_right;
    logic signed [15:0] foot_z_front_left;
    logic signed [15:0] foot_z_front_right;
    logic signed [15:0] foot_z_rear_left;
    logic signed [15:0] foot_z_rear_right;
  } tgft_out_t;

  // controller to datapath commands, one per step of the sequence
  typedef struct packed {
    logic load_in;
    logic prep;
    logic rom_rd;
    logic mul;
    logic fin;
  } tgft_cmd_t;

  // sine over the first quadrant, angle r of a circle of 2^addr_bits, Q30
  function automatic longint tgft_quad_sin(input int r, input int addr_bits);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    x = (64'(r) * TWO_PI_Q30) >> addr_bits;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return sum;
  endfunction

  // sin(2*pi*k/2^addr_bits), Q30
  function automatic longint tgft_sin_q30(input int k, input int addr_bits);
    int q;
    int quad;
    int r;
    longint res;
    q = 1 << (addr_bits - 2);
    quad = (k >> (addr_bits - 2)) & 3;
    r = k & (q - 1);
    case (quad)
      0: res = tgft_quad_sin(r, addr_bits);
      1: res = tgft_quad_sin(q - r, addr_bits);
      2: res = -tgft_quad_sin(r, addr_bits);
      default: res = -tgft_quad_sin(q - r, addr_bits);
    endcase
    return res;
  endfunction

  // cycloid c(ts) = ts - sin(2 pi ts)/(2 pi), unsigned Q16
  function automatic logic [TAB_W-1:0] tgft_c_entry(input int k, input int addr_bits);
    longint          s;
    longint unsigned mag;
    longint          sd;
    longint          base;
    longint          c;
    s = tgft_sin_q30(k, addr_bits);
    mag = 64'(s < 0 ? -s : s) << 16;
    sd = longint'((mag + HALF_TWO_PI_Q30) / TWO_PI_Q30);
    base = longint'(k) << (16 - addr_bits);
    c = (s < 0) ? base + sd : base - sd;
    if (c < 0) c = 0;
    if (c > 65536) c = 65536;
    return TAB_W'(c);
  endfunction

  // lift profile b(ts) = 0.5 - 0.5 cos(2 pi ts), unsigned Q16
  function automatic logic [TAB_W-1:0] tgft_b_entry(input int k, input int addr_bits);
    longint co;
    longint bv;
    int     n;
    n = 1 << addr_bits;
    co = tgft_sin_q30((k + (1 << (addr_bits - 2))) & (n - 1), addr_bits);
    bv = ONE_Q30 - co;
    if (bv < 0) bv = 0;
    return TAB_W'((bv + 64'sd16384) >>> 15);
  endfunction

  // clamp a 19-bit signed value to 16 bits
  function automatic logic signed [15:0] tgft_sat16(input logic signed [18:0] v);
    logic signed [15:0] res;
    if (v > 19'sd32767) res = 16'sh7fff;
    else if (v < -19'sd32768) res = 16'sh8000;
    else res = v[15:0];
    return res;
  endfunction

endpackage

// ----- design/tgft_rom.sv -----
// Constant c(ts) and b(ts) tables with a registered read port.
// Depends on tgft_pkg for the entry functions and widths.
module tgft_rom import tgft_pkg::*; #(
  parameter int ADDR_BITS = TGFT_TABLE_ADDR_BITS
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [TAB_W-1:0]     c_q,
  output logic [TAB_W-1:0]     b_q
);

  localparam int TAB_SIZE = 1 << ADDR_BITS;

  logic [TAB_W-1:0] c_tab [TAB_SIZE];
  logic [TAB_W-1:0] b_tab [TAB_SIZE];
  logic [TAB_W-1:0] c_q_r;
  logic [TAB_W-1:0] b_q_r;

  // table contents fixed at elaboration
  for (genvar k = 0; k < TAB_SIZE; k++) begin : g_tab
    localparam logic [TAB_W-1:0] C_VAL = tgft_c_entry(k, ADDR_BITS);
    localparam logic [TAB_W-1:0] B_VAL = tgft_b_entry(k, ADDR_BITS);
    assign c_tab[k] = C_VAL;
    assign b_tab[k] = B_VAL;
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      c_q_r <= c_tab[rd_addr];
      b_q_r <= b_tab[rd_addr];
    end
  end

  assign c_q = c_q_r;
  assign b_q = b_q_r;

endmodule

// ----- design/tgft_ctrl.sv -----
// Sequencer for the trot gait unit: handshakes and datapath step commands.
// Depends on tgft_pkg and the assertion macro header.
`include "trot_gait_foot_trajectory_unit_assert.svh"

module tgft_ctrl import tgft_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output tgft_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_ROM  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // step commands
  always_comb begin
    cmd.load_in = in_valid && in_ready;
    cmd.prep    = (state_r == S_PREP);
    cmd.rom_rd  = (state_r == S_ROM);
    cmd.mul     = (state_r == S_MUL);
    cmd.fin     = (state_r == S_FIN) && out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PREP;
      end
      S_PREP: state_nxt = S_ROM;
      S_ROM:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TGFT_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_r == S_PREP)
  `TGFT_ASSERT_SAME(a_valid_from_fin, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_FIN)
  `TGFT_ASSERT_NEXT(a_fin_waits, clk, rst_n, (state_r == S_FIN) && out_valid_r && !out_ready, (state_r == S_FIN) && out_valid_r)

endmodule

// ----- design/tgft_dpath.sv -----
// Datapath of the trot gait unit: config registers, phase, tables, products, output.
// Depends on tgft_pkg and tgft_rom.
module tgft_dpath import tgft_pkg::*; #(
  parameter int TABLE_ADDR_BITS = TGFT_TABLE_ADDR_BITS,
  parameter int PHASE_BITS      = TGFT_PHASE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tgft_cmd_t             cmd,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  tgft_in_t              in_data,
  output tgft_out_t             out_data
);

  // configuration registers
  logic [15:0]        phase_inc_r;
  logic [11:0]        lift_r;
  logic signed [13:0] body_shift_r;
  logic [11:0]        gain_r;
  logic [6:0]         deadzone_r;

  // working registers
  tgft_in_t                  in_r;
  logic [PHASE_BITS-1:0]     phase_r;
  logic [PHASE_BITS-1:0]     phase_nxt;
  logic signed [19:0]        len_r;
  logic [11:0]               hgt_r;
  logic signed [37:0]        px_r;
  logic [28:0]               pz_r;
  tgft_out_t                 out_r;
  tgft_out_t                 out_nxt;

  // prep step signals
  logic signed [8:0]         joy_ext;
  logic signed [8:0]         joy_neg;
  logic [7:0]                joy_mag;
  logic                      stop;
  logic signed [20:0]        len_full;
  logic [15+PHASE_BITS:0]    inc_ext;
  logic [PHASE_BITS-1:0]     inc;

  // table access
  logic [PHASE_BITS+TABLE_ADDR_BITS-2:0] ts_ext;
  logic [TABLE_ADDR_BITS-1:0]            tab_addr;
  logic [TAB_W-1:0]                      c_q;
  logic [TAB_W-1:0]                      b_q;
  logic signed [17:0]                    c_ofs;
  logic signed [37:0]                    px_full;

  // finish step signals
  logic signed [38:0] xs_sum;
  logic signed [38:0] xt_sum;
  logic signed [18:0] xs_b;
  logic signed [18:0] xt_b;
  logic signed [18:0] shift_ext;
  logic signed [30:0] zs_sum;
  logic signed [15:0] xs_sat;
  logic signed [15:0] xt_sat;
  logic signed [15:0] zs_sat;
  logic [28:0]        zt_sum;
  logic [27:0]        zt_prod;
  logic signed [15:0] zt_val;
  logic               swing_even;

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r  <= RST_PHASE_INC;
      lift_r       <= RST_LIFT;
      body_shift_r <= RST_BODY_SHIFT;
      gain_r       <= RST_GAIN;
      deadzone_r   <= RST_DEADZONE;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PHASE_INC:  phase_inc_r  <= cfg_wdata;
        CFG_LIFT:       lift_r       <= cfg_wdata[11:0];
        CFG_BODY_SHIFT: body_shift_r <= $signed(cfg_wdata[13:0]);
        CFG_GAIN:       gain_r       <= cfg_wdata[11:0];
        CFG_DEADZONE:   deadzone_r   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // stop detect, stride product and phase advance
  assign joy_ext  = {in_r.joystick_forward[7], in_r.joystick_forward};
  assign joy_neg  = -joy_ext;
  assign joy_mag  = joy_ext[8] ? joy_neg[7:0] : joy_ext[7:0];
  assign stop     = (joy_mag < {1'b0, deadzone_r}) && !in_r.march_in_place;
  assign len_full = in_r.joystick_forward * $signed({1'b0, gain_r});
  assign inc_ext  = {phase_inc_r, PHASE_BITS'(0)};
  assign inc      = inc_ext[15+PHASE_BITS:16];
  assign phase_nxt = stop ? '0 : phase_r + inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.prep) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_data;
    if (cmd.prep) begin
      len_r <= (stop || in_r.march_in_place) ? '0 : len_full[19:0];
      hgt_r <= stop ? '0 : lift_r;
    end
  end

  // table address: top bits of the half-cycle position; all four legs share it
  assign ts_ext   = {phase_r[PHASE_BITS-2:0], TABLE_ADDR_BITS'(0)};
  assign tab_addr = ts_ext[PHASE_BITS+TABLE_ADDR_BITS-2:PHASE_BITS-1];

  tgft_rom #(
    .ADDR_BITS(TABLE_ADDR_BITS)
  ) u_rom (
    .clk    (clk),
    .rd_en  (cmd.rom_rd),
    .rd_addr(tab_addr),
    .c_q    (c_q),
    .b_q    (b_q)
  );

  // products: L*(c - 1/2) and H*b
  assign c_ofs   = $signed({1'b0, c_q}) - 18'sd32768;
  assign px_full = len_r * c_ofs;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      px_r <= px_full;
      pz_r <= 29'(hgt_r * b_q);
    end
  end

  // x for swing and stance, rounded half up, shifted by the body offset
  assign shift_ext = {{5{body_shift_r[13]}}, body_shift_r};
  assign xs_sum = {px_r[37], px_r} + 39'sd131072;
  assign xt_sum = 39'sd131072 - {px_r[37], px_r};
  assign xs_b   = $signed({xs_sum[35], xs_sum[35:18]}) + shift_ext;
  assign xt_b   = $signed({xt_sum[35], xt_sum[35:18]}) + shift_ext;
  assign xs_sat = tgft_sat16(xs_b);
  assign xt_sat = tgft_sat16(xt_b);

  // swing z = round(-H*b / 2^14)
  assign zs_sum = 31'sd8192 - $signed({2'b00, pz_r});
  assign zs_sat = tgft_sat16({{2{zs_sum[30]}}, zs_sum[30:14]});

  // stance z = floor((H*b + 20*2^14) / (40*2^14)): shift by 2^17, then /5
  assign zt_sum  = pz_r + 29'd327680;
  assign zt_prod = zt_sum[28:17] * 16'd52429;
  assign zt_val  = $signed({6'b0, zt_prod[27:18]});

  assign swing_even = !phase_r[PHASE_BITS-1];

  always_comb begin
    out_nxt.foot_x_front_left  = swing_even ? xs_sat : xt_sat;
    out_nxt.foot_x_rear_left   = swing_even ? xs_sat : xt_sat;
    out_nxt.foot_x_front_right = swing_even ? xt_sat : xs_sat;
    out_nxt.foot_x_rear_right  = swing_even ? xt_sat : xs_sat;
    out_nxt.foot_z_front_left  = swing_even ? zs_sat : zt_val;
    out_nxt.foot_z_rear_left   = swing_even ? zs_sat : zt_val;
    out_nxt.foot_z_front_right = swing_even ? zt_val : zs_sat;
    out_nxt.foot_z_rear_right  = swing_even ? zt_val : zs_sat;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// ----- design/trot_gait_foot_trajectory_unit.sv -----
// Top level of the trot gait foot trajectory unit.
// Depends on tgft_pkg, tgft_ctrl and tgft_dpath.
//
// Usage:
//   in_*  : one transaction per gait tick (joystick_forward, march_in_place).
//   out_* : one transaction per tick with x and z offsets of all four feet,
//           signed 1/64 mm, held in an output register until taken.
//   cfg_* : register writes (index 0..4), always ready, one per cycle; write
//           only while no tick is in flight. Unknown indexes are dropped.
// The sequencer walks accept, prep, table read, multiply and finish steps for
//   one tick at a time; out_valid rises once the finish step loads the output
//   register, and no new tick is taken until the finish step completes.
// The next tick is taken while a result still waits in the output register;
//   if the receiver stalls, the following tick stops in its finish step until
//   the register frees, and in_ready stays low meanwhile.
// Reset (rst_n low, synchronous) clears the gait phase, restores the register
//   defaults and empties the output register. The tables are constants and
//   need no loading.
module trot_gait_foot_trajectory_unit import tgft_pkg::*; #(
  parameter int TABLE_ADDR_BITS = TGFT_TABLE_ADDR_BITS,
  parameter int PHASE_BITS      = TGFT_PHASE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tgft_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tgft_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  tgft_cmd_t cmd;

  // register writes never stall
  assign cfg_ready = 1'b1;

  tgft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  tgft_dpath #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS),
    .PHASE_BITS     (PHASE_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ----- verif/trot_gait_foot_trajectory_unit_tb.sv -----
// Self-checking testbench for the trot gait foot trajectory unit.
// Depends on tgft_pkg and trot_gait_foot_trajectory_unit; a scoreboard class
// predicts every tick's foot offsets and checks each result in order.
module trot_gait_foot_trajectory_unit_tb import tgft_pkg::*; ();

  localparam int          TAB_BITS     = TGFT_TABLE_ADDR_BITS;
  localparam int          PH_BITS      = TGFT_PHASE_BITS;
  localparam int unsigned PHASE_MASK   = (1 << PH_BITS) - 1;
  localparam int unsigned HALF_MASK    = (1 << (PH_BITS - 1)) - 1;
  localparam int          LATENCY      = 5;
  localparam int          RX_HOLD      = 300;
  localparam int          PHASE_TICKS  = 145;
  localparam int          LIMIT_CYCLES = 400000;

  // gait predictor plus in-order store of expected foot offsets
  class gait_scoreboard;
    int unsigned step_reg;
    int unsigned lift_reg;
    int          shift_reg;
    int unsigned gain_reg;
    int unsigned deadzone;
    int unsigned gait_phase;
    longint      cyc_tab[1 << TAB_BITS];
    longint      lift_tab[1 << TAB_BITS];
    tgft_out_t   expected_q[$];
    int          errors;
    string       field_label[8];

    function new();
      longint          s, co, sd, base, cv, bv;
      longint unsigned mag;
      int              n;
      n = 1 << TAB_BITS;
      // cycloid and lift profile tables, same rounding as the hardware ROM
      for (int k = 0; k < n; k++) begin
        s = circle_sine(k, n);
        co = circle_sine((k + n / 4) % n, n);
        mag = (s < 0) ? -s : s;
        mag = mag << 16;
        sd = longint'((mag + TWO_PI_Q30 / 2) / TWO_PI_Q30);
        base = longint'(k) << (16 - TAB_BITS);
        cv = (s < 0) ? base + sd : base - sd;
        if (cv < 0) cv = 0;
        if (cv > 65536) cv = 65536;
        bv = ONE_Q30 - co;
        if (bv < 0) bv = 0;
        cyc_tab[k] = cv;
        lift_tab[k] = (bv + 16384) >>> 15;
      end
      step_reg = RST_PHASE_INC;
      lift_reg = RST_LIFT;
      shift_reg = RST_BODY_SHIFT;
      gain_reg = RST_GAIN;
      deadzone = RST_DEADZONE;
      gait_phase = 0;
      errors = 0;
      field_label = '{"foot_x_front_left", "foot_x_front_right", "foot_x_rear_left",
                      "foot_x_rear_right", "foot_z_front_left", "foot_z_front_right",
                      "foot_z_rear_left", "foot_z_rear_right"};
    endfunction

    // Taylor series sine over the first quadrant, angle r of a circle of n, Q30
    function longint quad_sine(longint unsigned r, longint unsigned n);
      longint unsigned x, term;
      longint          acc;
      x = (r * TWO_PI_Q30) / n;
      term = x;
      acc = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      return acc;
    endfunction

    function longint circle_sine(int k, int n);
      int q, quad, r;
      q = n / 4;
      quad = (k / q) % 4;
      r = k % q;
      case (quad)
        0: return quad_sine(r, n);
        1: return quad_sine(q - r, n);
        2: return -quad_sine(r, n);
        default: return -quad_sine(q - r, n);
      endcase
    endfunction

    // add half of 2^sh, then floor
    function longint round_shift(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PHASE_INC:  step_reg = val;
        CFG_LIFT:       lift_reg = val[11:0];
        CFG_BODY_SHIFT: shift_reg = $signed(val[13:0]);
        CFG_GAIN:       gain_reg = val[11:0];
        CFG_DEADZONE:   deadzone = val[6:0];
        default: ;
      endcase
    endfunction

    // advance the gait by one tick and queue the foot offsets it yields
    function void note_tick(tgft_in_t t);
      int                 joy;
      int unsigned        mag, inc, p, ts, addr;
      longint             len, hgt, c, b, x, z;
      bit                 stance;
      logic signed [15:0] v[8];
      joy = t.joystick_forward;
      mag = (joy < 0) ? -joy : joy;
      len = 0;
      hgt = 0;
      if (mag < deadzone && !t.march_in_place) begin
        gait_phase = 0;
      end else begin
        if (!t.march_in_place) len = longint'(joy) * longint'(gain_reg);
        hgt = lift_reg;
        inc = (PH_BITS >= 16) ? step_reg << (PH_BITS - 16) : step_reg >> (16 - PH_BITS);
        gait_phase = (gait_phase + inc) & PHASE_MASK;
      end
      for (int leg = 0; leg < 4; leg++) begin
        p = gait_phase;
        // right-hand legs run half a cycle apart
        if (leg % 2 == 1) p = p ^ (1 << (PH_BITS - 1));
        stance = (p >> (PH_BITS - 1)) & 1;
        ts = p & HALF_MASK;
        if (PH_BITS - 1 >= TAB_BITS) addr = ts >> (PH_BITS - 1 - TAB_BITS);
        else addr = ts << (TAB_BITS - (PH_BITS - 1));
        addr = addr & ((1 << TAB_BITS) - 1);
        c = cyc_tab[addr];
        b = lift_tab[addr];
        if (!stance) begin
          x = round_shift(len * c - len * 32768, 18);
          z = round_shift(-(hgt * b), 14);
        end else begin
          x = round_shift(len * 32768 - len * c, 18);
          z = (hgt * b + 20 * 16384) / (40 * 16384);
        end
        v[leg] = clamp16(x + shift_reg);
        v[4 + leg] = clamp16(z);
      end
      expected_q.push_back({v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]});
    endfunction

    function void check_result(tgft_out_t got);
      tgft_out_t          want;
      logic signed [15:0] e[8];
      logic signed [15:0] a[8];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with no tick pending, expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7]} = want;
      {a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7]} = got;
      for (int i = 0; i < 8; i++) begin
        if (e[i] !== a[i]) begin
          errors++;
          $display("%0t: %s expected %0d actual %0d", $time, field_label[i], e[i], a[i]);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  tgft_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  tgft_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                  rx_hold = 1'b0;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  gait_scoreboard        sb;

  trot_gait_foot_trajectory_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random back-pressure, or a long hold-off while rx_hold is set
  always @(posedge clk) begin
    if (rx_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitor: register writes, ticks and results, in that order per edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_addr, cfg_wdata);
      if (in_valid && in_ready) sb.note_tick(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  function automatic tgft_in_t tick(int joy, bit march);
    tgft_in_t t;
    t.joystick_forward = 8'(joy);
    t.march_in_place = march;
    return t;
  endfunction

  // mostly walking ticks outside the deadzone, some marching, some noise
  function automatic tgft_in_t random_tick(int unsigned dz);
    int unsigned pick, mag;
    pick = $urandom_range(0, 99);
    if (pick < 15) return tick($urandom_range(0, 255), $urandom_range(0, 1));
    if (pick < 25) return tick($urandom_range(0, 255), 1'b1);
    mag = $urandom_range(dz, 128);
    if (mag == 128) return tick(-128, 1'b0);
    return tick($urandom_range(0, 1) ? -int'(mag) : int'(mag), 1'b0);
  endfunction

  // register value: an extreme of the field or random, upper bits random too
  function automatic logic [CFG_DATA_W-1:0] reg_value(logic [CFG_ADDR_W-1:0] idx);
    logic [CFG_DATA_W-1:0] lo, hi;
    int unsigned           pick;
    case (idx)
      CFG_PHASE_INC:  begin lo = 16'h0000; hi = 16'hffff; end
      CFG_LIFT:       begin lo = 16'h0000; hi = 16'h0fff; end
      CFG_BODY_SHIFT: begin lo = 16'h2000; hi = 16'h1fff; end
      CFG_GAIN:       begin lo = 16'h0000; hi = 16'h0fff; end
      default:        begin lo = 16'h0000; hi = 16'h007f; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 20) return lo;
    if (pick < 40) return hi;
    return 16'($urandom);
  endfunction

  task automatic send_tick(tgft_in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all five registers plus one write to an unmapped index
  task automatic apply_config(logic [15:0] step, logic [15:0] lift, logic [15:0] shift,
                              logic [15:0] gain, logic [15:0] dz);
    write_reg(CFG_PHASE_INC, step);
    write_reg(CFG_LIFT, lift);
    write_reg(CFG_BODY_SHIFT, shift);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_DEADZONE, dz);
    write_reg(CFG_DEADZONE + CFG_ADDR_W'($urandom_range(1, 3)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // wait until every tick's result has come back and the pipeline is empty
  task automatic drain();
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic stall_receiver();
    fork
      begin
        rx_hold <= 1'b1;
        repeat (RX_HOLD) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: deadzone edges, joystick extremes, marching, reset defaults
    send_tick(tick(0, 0));
    send_tick(tick(4, 0));
    send_tick(tick(-4, 0));
    send_tick(tick(5, 0));
    send_tick(tick(-5, 0));
    send_tick(tick(127, 0));
    send_tick(tick(-128, 0));
    send_tick(tick(0, 1));
    send_tick(tick(-128, 1));
    send_tick(tick(3, 0));
    in_valid <= 1'b0;

    // directed: largest stride, lift and shift, quarter-cycle steps, no deadzone
    drain();
    apply_config(16'd16384, 16'hffff, 16'hdfff, 16'hffff, 16'd0);
    repeat (4) send_tick(tick(127, 0));
    repeat (2) send_tick(tick(-128, 0));
    send_tick(tick(0, 0));
    in_valid <= 1'b0;

    // directed: most negative shift, full phase step, widest deadzone
    drain();
    apply_config(16'hffff, 16'h0000, 16'h2000, 16'h0000, 16'h007f);
    send_tick(tick(126, 0));
    send_tick(tick(127, 0));
    send_tick(tick(-128, 0));
    send_tick(tick(-127, 1));
    send_tick(tick(-128, 0));
    in_valid <= 1'b0;

    // random phases: new settings each, sender/receiver idling varied
    for (int ph = 0; ph < 9; ph++) begin
      drain();
      apply_config(reg_value(CFG_PHASE_INC), reg_value(CFG_LIFT), reg_value(CFG_BODY_SHIFT),
                   reg_value(CFG_GAIN), reg_value(CFG_DEADZONE));
      send_idle_pct = (ph < 3) ? 12 : (ph < 6) ? 79 : 0;
      recv_idle_pct <= (ph < 3) ? 79 : (ph < 6) ? 12 : 0;
      if (ph == 1 || ph == 6) stall_receiver();
      repeat (PHASE_TICKS) send_tick(random_tick(sb.deadzone));
      in_valid <= 1'b0;
    end

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("trot_gait_foot_trajectory_unit: match");
    end else begin
      $display("trot_gait_foot_trajectory_unit: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("trot_gait_foot_trajectory_unit: mismatch");
    $finish;
  end

endmodule
